[rtl/core/oas_pkg.sv]
// Shared constants, types and control structures for the ordered array store.
package oas_pkg;

  // Number of storage cells in the chain.
  localparam int DEPTH = 64;

  // Widths derived from the depth.
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed payload widths.
  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int STAT_W = 3;
  localparam int FPOS_W = 6;
  localparam int LEN_W  = 7;

  // Common width for comparing positions, counts and cell indices.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_RANGE    = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_DELETE,
    MODE_ROTATE
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_t               mode;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
  } cell_ctrl_t;

  // One finished result.
  typedef struct packed {
    status_t                  status;
    logic [FPOS_W-1:0]        fpos;
    logic signed [WORD_W-1:0] rval;
    logic [LEN_W-1:0]         length;
  } result_t;

endpackage

[rtl/core/oas_cell.sv]
// One storage cell of the chain: holds a word and takes a neighbour's word on a shift, or the new word on an insert.
module oas_cell (
  input  logic                               clk,
  input  logic [oas_pkg::IDX_W-1:0]          idx,
  input  logic signed [oas_pkg::WORD_W-1:0]  below,
  input  logic signed [oas_pkg::WORD_W-1:0]  above,
  input  oas_pkg::cell_ctrl_t                ctrl,
  output logic signed [oas_pkg::WORD_W-1:0]  word
);

  logic [oas_pkg::CMP_W-1:0] idx_w;
  logic [oas_pkg::CMP_W-1:0] pos_w;
  logic signed [oas_pkg::WORD_W-1:0] word_next;

  assign idx_w = oas_pkg::CMP_W'(idx);
  assign pos_w = oas_pkg::CMP_W'(ctrl.pos);

  always_comb begin
    word_next = word;
    case (ctrl.mode)
      oas_pkg::MODE_INSERT: begin
        // Cells above the insertion point take the word from below.
        if (idx_w > pos_w) begin
          word_next = below;
        end else if (idx_w == pos_w) begin
          word_next = ctrl.val;
        end
      end
      oas_pkg::MODE_DELETE: begin
        if (idx_w >= pos_w) begin
          word_next = above;
        end
      end
      oas_pkg::MODE_ROTATE: begin
        word_next = above;
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

[rtl/core/oas_ctrl.sv]
// Command sequencer: checks commands, drives the cell chain and scans it for find and read.
module oas_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  logic [oas_pkg::CMD_W-1:0]          command,
  input  logic [oas_pkg::POS_W-1:0]          position,
  input  logic signed [oas_pkg::WORD_W-1:0]  value,
  input  logic signed [oas_pkg::WORD_W-1:0]  head,
  output oas_pkg::cell_ctrl_t                cell_ctrl,
  output logic                               res_valid,
  output oas_pkg::result_t                   res,
  input  logic                               res_take
);

  oas_pkg::state_t  state, state_next;
  oas_pkg::cmd_t    op;
  oas_pkg::cmd_t    cmd_in;
  oas_pkg::result_t pend;
  oas_pkg::result_t res_now;

  logic [oas_pkg::IDX_W-1:0]         step;
  logic [oas_pkg::CNT_W-1:0]         count, count_next;
  logic [oas_pkg::POS_W-1:0]         pos_q;
  logic signed [oas_pkg::WORD_W-1:0] val_q;
  logic                              found;
  logic [oas_pkg::IDX_W-1:0]         fpos_q;
  logic signed [oas_pkg::WORD_W-1:0] rval_q;

  logic                      accept;
  logic                      last;
  logic                      hit_find;
  logic                      hit_read;
  logic                      fin;
  logic [oas_pkg::CMP_W-1:0] count_w;
  logic [oas_pkg::CMP_W-1:0] pos_w;
  logic [oas_pkg::CMP_W-1:0] pos_q_w;
  logic [oas_pkg::CMP_W-1:0] step_w;
  logic [oas_pkg::CMP_W-1:0] fpos_w;

  assign cmd_in  = oas_pkg::cmd_t'(command);
  assign accept  = cmd_valid && cmd_ready;
  assign count_w = oas_pkg::CMP_W'(count);
  assign pos_w   = oas_pkg::CMP_W'(position);
  assign pos_q_w = oas_pkg::CMP_W'(pos_q);
  assign step_w  = oas_pkg::CMP_W'(step);
  assign last    = (step == oas_pkg::IDX_W'(oas_pkg::DEPTH - 1));

  // The word at the head of the chain is element number step during a scan.
  assign hit_find = (op == oas_pkg::CMD_FIND) && !found && (step_w < count_w) &&
                    (head == val_q);
  assign hit_read = (op == oas_pkg::CMD_READ) && (step_w == pos_q_w);
  assign fpos_w   = found ? oas_pkg::CMP_W'(fpos_q) : step_w;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      oas_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_in == oas_pkg::CMD_FIND || cmd_in == oas_pkg::CMD_READ) begin
            state_next = oas_pkg::ST_SCAN;
          end else if (!res_take) begin
            state_next = oas_pkg::ST_HOLD;
          end
        end
      end
      oas_pkg::ST_SCAN: begin
        if (last) begin
          state_next = res_take ? oas_pkg::ST_IDLE : oas_pkg::ST_HOLD;
        end
      end
      oas_pkg::ST_HOLD: begin
        if (res_take) begin
          state_next = oas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oas_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs, cell control and the result being finished this cycle.
  always_comb begin
    cmd_ready      = (state == oas_pkg::ST_IDLE);
    cell_ctrl.mode = oas_pkg::MODE_HOLD;
    cell_ctrl.pos  = position;
    cell_ctrl.val  = value;
    count_next     = count;
    fin            = 1'b0;
    res_now.status = oas_pkg::STAT_OK;
    res_now.fpos   = '0;
    res_now.rval   = '0;
    res_now.length = oas_pkg::LEN_W'(count_w);
    case (state)
      oas_pkg::ST_IDLE: begin
        if (accept && cmd_in == oas_pkg::CMD_INSERT) begin
          fin = 1'b1;
          if (count_w == oas_pkg::CMP_W'(oas_pkg::DEPTH)) begin
            res_now.status = oas_pkg::STAT_FULL;
          end else if (pos_w > count_w) begin
            res_now.status = oas_pkg::STAT_RANGE;
          end else begin
            cell_ctrl.mode = oas_pkg::MODE_INSERT;
            count_next     = count + oas_pkg::CNT_W'(1);
          end
        end else if (accept && cmd_in == oas_pkg::CMD_DELETE) begin
          fin = 1'b1;
          if (count_w == '0) begin
            res_now.status = oas_pkg::STAT_EMPTY;
          end else if (pos_w >= count_w) begin
            res_now.status = oas_pkg::STAT_RANGE;
          end else begin
            cell_ctrl.mode = oas_pkg::MODE_DELETE;
            count_next     = count - oas_pkg::CNT_W'(1);
          end
        end
        res_now.length = oas_pkg::LEN_W'(oas_pkg::CMP_W'(count_next));
      end
      oas_pkg::ST_SCAN: begin
        cell_ctrl.mode = oas_pkg::MODE_ROTATE;
        fin            = last;
        if (op == oas_pkg::CMD_FIND) begin
          if (found || hit_find) begin
            res_now.fpos = oas_pkg::FPOS_W'(fpos_w);
          end else begin
            res_now.status = oas_pkg::STAT_NOTFOUND;
          end
        end else if (pos_q_w >= count_w) begin
          res_now.status = oas_pkg::STAT_RANGE;
        end else begin
          res_now.rval = hit_read ? head : rval_q;
        end
      end
      oas_pkg::ST_HOLD: begin
        fin     = 1'b1;
        res_now = pend;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign res_valid = fin;
  assign res       = res_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oas_pkg::ST_IDLE;
      count <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) begin
        found <= 1'b0;
      end else if (hit_find) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= cmd_in;
      pos_q  <= position;
      val_q  <= value;
      step   <= '0;
      fpos_q <= '0;
      rval_q <= '0;
    end else if (state == oas_pkg::ST_SCAN) begin
      step <= step + oas_pkg::IDX_W'(1);
      if (hit_find) begin
        fpos_q <= step;
      end
      if (hit_read) begin
        rval_q <= head;
      end
    end
    if (fin && state != oas_pkg::ST_HOLD) begin
      pend <= res_now;
    end
  end

endmodule

[rtl/core/ordered_array_store.sv]
// Top level of the ordered array store: cell chain, command sequencer and result register.
//
// Usage. Commands arrive as beats on the cmd channel (command, position, value) and
// each one yields exactly one beat on the rsp channel (status, found_position,
// read_value, length). Both channels use valid and ready.
// Insert and delete are checked and applied in the cycle their beat is accepted:
// every cell compares its own index against the position and takes the word of its
// lower or upper neighbour, or the new word, all in parallel. Their result enters the
// output register at the accepting edge and is offered from the next cycle, and the
// next command can be taken in that cycle, so while the receiver keeps up they take
// one cycle per beat. Find and read rotate the ring of cells once round while the
// sequencer watches the word at the head; a full turn puts every word back in place.
// Their result is finished in the last cycle of that rotation.
// A new command is taken only once the previous one has finished; a finished result
// may still wait in the output register while the next command is accepted.
// When the receiver stalls, a result that cannot enter the output register waits in
// the sequencer and no further command is taken until it moves on.
// Reset empties the list (length zero) and the output register; the cell contents are
// left as they are, since no word at or beyond the length is ever looked at.
module ordered_array_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  logic [oas_pkg::CMD_W-1:0]          command,
  input  logic [oas_pkg::POS_W-1:0]          position,
  input  logic signed [oas_pkg::WORD_W-1:0]  value,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [oas_pkg::STAT_W-1:0]         status,
  output logic [oas_pkg::FPOS_W-1:0]         found_position,
  output logic signed [oas_pkg::WORD_W-1:0]  read_value,
  output logic [oas_pkg::LEN_W-1:0]          length
);

  // Words held by the cells; index 0 is the head of the list.
  logic signed [oas_pkg::WORD_W-1:0] words [oas_pkg::DEPTH];

  oas_pkg::cell_ctrl_t cell_ctrl;
  oas_pkg::result_t    res;
  logic                res_valid;
  logic                res_take;

  // The output register can take a result when it is empty or being emptied.
  assign res_take = !rsp_valid || rsp_ready;

  oas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .position  (position),
    .value     (value),
    .head      (words[0]),
    .cell_ctrl (cell_ctrl),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The cells form a ring: each sees its neighbours, and the top cell's upper
  // neighbour is the head, which closes the loop used for rotation.
  for (genvar i = 0; i < oas_pkg::DEPTH; i++) begin : g_cell
    oas_cell u_cell (
      .clk   (clk),
      .idx   (oas_pkg::IDX_W'(i)),
      .below (words[(i + oas_pkg::DEPTH - 1) % oas_pkg::DEPTH]),
      .above (words[(i + 1) % oas_pkg::DEPTH]),
      .ctrl  (cell_ctrl),
      .word  (words[i])
    );
  end

  // Output register for the rsp channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      status         <= res.status;
      found_position <= res.fpos;
      read_value     <= res.rval;
      length         <= res.length;
    end
  end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the ordered array store, with a predictor held alongside the block.
module tb_top;
  import oas_pkg::*;

  // One command beat as it travels on the command channel.
  typedef struct packed {
    cmd_t                     cmd;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
  } command_beat_t;

  localparam int RANDOM_ITEMS = 1800;
  // Long enough for a find or read rotation to finish after the last beat.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int MAX_REPORTS  = 10;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cmd_valid = 1'b0;
  logic                     cmd_ready;
  logic [CMD_W-1:0]         command = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  logic [STAT_W-1:0]        status;
  logic [FPOS_W-1:0]        found_position;
  logic signed [WORD_W-1:0] read_value;
  logic [LEN_W-1:0]         length;

  ordered_array_store DUT (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .command        (command),
    .position       (position),
    .value          (value),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .found_position (found_position),
    .read_value     (read_value),
    .length         (length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands waiting to be offered, and the results that accepted commands still owe.
  command_beat_t   commands_pending[$];
  result_t         results_due[$];

  // The predictor's own copy of the list. Words at or beyond list_len are never read.
  logic signed [WORD_W-1:0] list_words[DEPTH];
  int                       list_len = 0;

  int cmds_queued   = 0;
  int cmds_accepted = 0;
  int rsps_checked  = 0;
  int mismatches    = 0;
  int cmd_tally[4];
  int status_tally[5];

  // Applies one command to the predicted list and returns the result it must produce.
  // A failing command leaves the list exactly as it was.
  function automatic result_t apply_to_list(command_beat_t c);
    result_t r;
    int      i;
    int      p;
    r = '0;
    r.status = STAT_OK;
    p = int'(c.pos);
    case (c.cmd)
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (p > list_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = c.val;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (p >= list_len) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      CMD_FIND: begin
        r.status = STAT_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == c.val) begin
            r.status = STAT_OK;
            r.fpos = FPOS_W'(i);
            break;
          end
        end
      end
      default: begin
        if (p >= list_len) r.status = STAT_RANGE;
        else r.rval = list_words[p];
      end
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  // The idling pattern moves through four phases as beats are accepted: none at all,
  // the sender idle most of the time, the receiver stalling most of the time, and both
  // idling now and then. Cycling through them repeatedly lets gaps land on inserts,
  // deletes and the long rotations alike.
  function automatic int idle_phase();
    return (cmds_accepted / 120) % 4;
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      1:       return 58;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_phase())
      2:       return 58;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  // Command driver. A beat that has not been taken is held unchanged; otherwise the
  // next pending command is offered unless this cycle is an idle one. The prediction
  // is made at the very edge where the beat is accepted, so it follows the order in
  // which the block really sees commands.
  always @(posedge clk) begin
    command_beat_t nxt;
    command_beat_t taken;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        taken.cmd = cmd_t'(command);
        taken.pos = position;
        taken.val = value;
        results_due.push_back(apply_to_list(taken));
        cmd_tally[command]++;
        cmds_accepted++;
      end
      if (cmd_valid && !cmd_ready) begin
        // Beat still on offer; leave everything as it stands.
      end else if (commands_pending.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        nxt = commands_pending.pop_front();
        cmd_valid <= 1'b1;
        command   <= nxt.cmd;
        position  <= nxt.pos;
        value     <= nxt.val;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result monitor. Each result beat is checked field by field against the oldest
  // outstanding prediction; a beat with nothing owed counts as a failure too.
  always @(posedge clk) begin
    result_t want;
    logic    bad;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result beat with none outstanding: status %0d length %0d",
                     $realtime, status, length);
        end else begin
          want = results_due.pop_front();
          bad = (status != want.status) || (found_position != want.fpos) ||
                (read_value != want.rval) || (length != want.length);
          if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] result %0d differs: expected status %0d fpos %0d rval %0d len %0d",
                       $realtime, rsps_checked, want.status, want.fpos, want.rval,
                       want.length);
              $display("    got status %0d fpos %0d rval %0d len %0d",
                       status, found_position, read_value, length);
            end
          end
          if (int'(want.status) < 5) status_tally[want.status]++;
          rsps_checked++;
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  // Stimulus construction. gen_len follows the list length as the commands will move
  // it, which lets the random part aim most positions at live entries.
  int                       gen_len = 0;
  logic signed [WORD_W-1:0] value_pool[8];

  function automatic void queue_command(cmd_t c, int p, logic signed [WORD_W-1:0] v);
    command_beat_t b;
    b.cmd = c;
    b.pos = POS_W'(p);
    b.val = v;
    commands_pending.push_back(b);
    cmds_queued++;
    case (c)
      CMD_INSERT: if (gen_len < DEPTH && p <= gen_len) gen_len++;
      CMD_DELETE: if (gen_len > 0 && p < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  // Mostly a position inside the live range, now and then anything the port allows.
  function automatic int pick_position(int upper);
    if ($urandom_range(99) < 15 || upper < 0) return $urandom_range((1 << POS_W) - 1);
    return $urandom_range(upper, 0);
  endfunction

  // Pool values repeat often, so finds hit and duplicates test the first-match rule.
  function automatic logic signed [WORD_W-1:0] pick_value();
    if ($urandom_range(99) < 50) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin
    int   n;
    int   roll;
    int   ins_w;
    int   del_w;
    int   fnd_w;
    cmd_t c;

    foreach (cmd_tally[k]) cmd_tally[k] = 0;
    foreach (status_tally[k]) status_tally[k] = 0;
    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    for (n = 5; n < 8; n++) value_pool[n] = $urandom;

    // Directed opening: every command against an empty list, the extreme words, an
    // append, a middle insert, duplicates and the largest position the port can carry.
    queue_command(CMD_READ,   0,   0);
    queue_command(CMD_DELETE, 0,   0);
    queue_command(CMD_FIND,   0,   0);
    queue_command(CMD_INSERT, 1,   32'sd9);
    queue_command(CMD_DELETE, 127, 0);
    queue_command(CMD_READ,   127, 0);
    queue_command(CMD_INSERT, 0,   32'sh7FFF_FFFF);
    queue_command(CMD_INSERT, 1,   32'sh8000_0000);
    queue_command(CMD_INSERT, 0,   0);
    queue_command(CMD_INSERT, 1,   -32'sd1);
    queue_command(CMD_INSERT, 127, 32'sd5);
    queue_command(CMD_INSERT, 4,   32'sh5555_5555);
    queue_command(CMD_INSERT, 2,   32'shAAAA_AAAA);
    queue_command(CMD_INSERT, 6,   0);
    queue_command(CMD_FIND,   0,   32'sh8000_0000);
    queue_command(CMD_FIND,   0,   0);
    queue_command(CMD_FIND,   0,   32'sd12345);
    queue_command(CMD_READ,   0,   0);
    queue_command(CMD_READ,   6,   0);
    queue_command(CMD_READ,   7,   0);
    queue_command(CMD_DELETE, 7,   0);
    queue_command(CMD_DELETE, 0,   0);
    queue_command(CMD_DELETE, 5,   0);
    queue_command(CMD_DELETE, 2,   0);
    queue_command(CMD_READ,   1,   0);

    // Random part in blocks: filling runs that reach a full list and stay there a while,
    // mixed runs, and draining runs that reach the empty list.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 150) % 3)
        0:       begin ins_w = 75; del_w = 5;  fnd_w = 10; end
        1:       begin ins_w = 35; del_w = 25; fnd_w = 20; end
        default: begin ins_w = 10; del_w = 65; fnd_w = 12; end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_w) c = CMD_INSERT;
      else if (roll < ins_w + del_w) c = CMD_DELETE;
      else if (roll < ins_w + del_w + fnd_w) c = CMD_FIND;
      else c = CMD_READ;
      case (c)
        CMD_INSERT: queue_command(c, pick_position(gen_len), pick_value());
        CMD_FIND:   queue_command(c, $urandom_range((1 << POS_W) - 1), pick_value());
        default:    queue_command(c, pick_position(gen_len - 1), $urandom);
      endcase
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmds_accepted < cmds_queued) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    // Any stray beat after the last expected one is caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d insert, %0d delete, %0d find, %0d read.",
             cmds_accepted, cmd_tally[CMD_INSERT], cmd_tally[CMD_DELETE],
             cmd_tally[CMD_FIND], cmd_tally[CMD_READ]);
    $display("Outcomes checked: %0d ok, %0d full, %0d range, %0d not found, %0d empty.",
             status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_RANGE],
             status_tally[STAT_NOTFOUND], status_tally[STAT_EMPTY]);
    if (mismatches == 0) begin
      $display("ordered_array_store regression: pass");
    end else begin
      $display("%0d result failures.", mismatches);
      $display("ordered_array_store regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legitimate run.
  initial begin
    #(8 * 1000000);
    $display("Timed out with %0d results outstanding.", results_due.size());
    $display("ordered_array_store regression: fail");
    $finish;
  end

endmodule
